### rtl/spr_pkg.sv
// Package with the constants, codes and types of the Bellman-Ford shortest path block.
`default_nettype none

package spr_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_EDGES    = 4096;

  localparam int unsigned VERTEX_W = 10;
  localparam int unsigned VCOUNT_W = 11;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned DIST_W   = 31;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned VADDR_W  = $clog2(MAX_VERTICES);
  localparam int unsigned EADDR_W  = $clog2(MAX_EDGES);
  localparam int unsigned ECOUNT_W = EADDR_W + 1;
  localparam int unsigned VIDX_W   = VADDR_W + 1;

  localparam logic [DIST_W-1:0] INF = {DIST_W{1'b1}};

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 2'd1;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(MAX_VERTICES);

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [VERTEX_W-1:0] to;
    logic [VERTEX_W-1:0] from;
  } edge_t;

endpackage

`default_nettype wire

### rtl/shortest_path_edge_relaxation_top.sv
// Bellman-Ford single-source shortest path engine with edge and distance memories.
//
// Input items arrive on in_valid/in_stall and results leave on out_valid/out_stall;
// a transfer happens on a rising edge with valid high and stall low. op 0 stores one
// edge and gives no result. op 2 reads one distance: the read is registered at the
// transfer and the answer enters the output register once it is free. op 1 runs the
// search: a sweep over all 1024 entries sets every distance to infinity (the source
// to zero), then each pass walks the stored edges through S_PASS_CHK, S_EDGE_RD and
// S_DIST_RD (edge read, two distance reads, add, compare and write-back through one
// shared adder). Passes stop after vertex_count-1 or after a pass that changes
// nothing. One run-finished result then follows and the edge list is cleared. The
// block takes no new item while a read or a run is in progress. A result waits
// in the output register while out_stall is high; loads are still taken meanwhile.
// Configuration writes on cfg_we are taken at any time but are meant for idle times.
// Reset (rst_n low, synchronous) empties the edge list, clears the dropped flag and
// out_valid and sets vertex_count to 1024 and source_vertex to 0.
`default_nettype none

module shortest_path_edge_relaxation_top (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [spr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [spr_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [spr_pkg::OP_W-1:0]              in_op,
  input  wire  [spr_pkg::VERTEX_W-1:0]          in_edge_from,
  input  wire  [spr_pkg::VERTEX_W-1:0]          in_edge_to,
  input  wire  [spr_pkg::WEIGHT_W-1:0]          in_edge_weight,
  input  wire  [spr_pkg::VERTEX_W-1:0]          in_query_vertex,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  out_result_kind,
  output logic [spr_pkg::DIST_W-1:0]            out_distance,
  output logic                                  out_unreachable,
  output logic [spr_pkg::STATUS_W-1:0]          out_status
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INIT     = 3'd1;
  localparam logic [2:0] S_PASS_CHK = 3'd2;
  localparam logic [2:0] S_EDGE_RD  = 3'd3;
  localparam logic [2:0] S_DIST_RD  = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;
  localparam logic [2:0] S_QOUT     = 3'd6;

  spr_pkg::edge_t                    edge_mem [spr_pkg::MAX_EDGES];
  logic [spr_pkg::DIST_W-1:0]        dist_mem [spr_pkg::MAX_VERTICES];

  logic [2:0]                        state_r, state_nxt;
  logic [spr_pkg::VCOUNT_W-1:0]      vertex_count_r;
  logic [spr_pkg::VERTEX_W-1:0]      source_vertex_r;
  logic [spr_pkg::ECOUNT_W-1:0]      edges_loaded_r, edges_loaded_nxt;
  logic                              edges_dropped_r, edges_dropped_nxt;
  logic [spr_pkg::VIDX_W-1:0]        init_cnt_r, init_cnt_nxt;
  logic [spr_pkg::ECOUNT_W-1:0]      edge_idx_r, edge_idx_nxt;
  logic [spr_pkg::VADDR_W-1:0]       pass_r, pass_nxt;
  logic                              changed_r, changed_nxt;
  logic                              q_range_r, q_range_nxt;

  spr_pkg::edge_t                    edge_q;
  logic [spr_pkg::DIST_W-1:0]        dist_a_q, dist_b_q;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_kind_r, out_kind_nxt;
  logic [spr_pkg::DIST_W-1:0]        out_dist_r, out_dist_nxt;
  logic                              out_unr_r, out_unr_nxt;
  logic [spr_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;

  logic [spr_pkg::VCOUNT_W-1:0]      used_n;
  logic                              in_xfer;
  logic                              out_free;
  logic                              dist_rd_en;
  logic [spr_pkg::VADDR_W-1:0]       dist_addr_a, dist_addr_b;
  logic                              dist_we;
  logic [spr_pkg::VADDR_W-1:0]       dist_waddr;
  logic [spr_pkg::DIST_W-1:0]        dist_wdata;
  logic                              edge_we;
  logic [spr_pkg::DIST_W:0]          relax_sum;
  logic                              relax_hit;
  logic [spr_pkg::VCOUNT_W-1:0]      pass_next_cnt;

  always_comb begin
    if (vertex_count_r == '0) begin
      used_n = spr_pkg::VCOUNT_W'(1);
    end else if (vertex_count_r > spr_pkg::VCOUNT_W'(spr_pkg::MAX_VERTICES)) begin
      used_n = spr_pkg::VCOUNT_W'(spr_pkg::MAX_VERTICES);
    end else begin
      used_n = vertex_count_r;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign relax_sum = {1'b0, dist_a_q} + {{(spr_pkg::DIST_W + 1 - spr_pkg::WEIGHT_W){1'b0}},
                                          edge_q.weight};
  assign relax_hit = ({1'b0, edge_q.from} < used_n) && ({1'b0, edge_q.to} < used_n) &&
                     (dist_a_q != spr_pkg::INF) && (relax_sum < {1'b0, dist_b_q});
  assign pass_next_cnt = {1'b0, pass_r} + spr_pkg::VCOUNT_W'(2);

  assign dist_rd_en  = (state_r == S_IDLE) || (state_r == S_EDGE_RD);
  assign dist_addr_a = (state_r == S_IDLE) ? in_query_vertex : edge_q.from;
  assign dist_addr_b = edge_q.to;
  assign edge_we     = in_xfer && (in_op == spr_pkg::OP_LOAD) &&
                       (edges_loaded_r < spr_pkg::ECOUNT_W'(spr_pkg::MAX_EDGES));

  always_comb begin
    state_nxt         = state_r;
    edges_loaded_nxt  = edges_loaded_r;
    edges_dropped_nxt = edges_dropped_r;
    init_cnt_nxt      = init_cnt_r;
    edge_idx_nxt      = edge_idx_r;
    pass_nxt          = pass_r;
    changed_nxt       = changed_r;
    q_range_nxt       = q_range_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_kind_nxt      = out_kind_r;
    out_dist_nxt      = out_dist_r;
    out_unr_nxt       = out_unr_r;
    out_status_nxt    = out_status_r;
    dist_we           = 1'b0;
    dist_waddr        = edge_q.to;
    dist_wdata        = relax_sum[spr_pkg::DIST_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            spr_pkg::OP_LOAD: begin
              if (edge_we) begin
                edges_loaded_nxt = edges_loaded_r + spr_pkg::ECOUNT_W'(1);
              end else begin
                edges_dropped_nxt = 1'b1;
              end
            end
            spr_pkg::OP_RUN: begin
              init_cnt_nxt = '0;
              state_nxt    = S_INIT;
            end
            spr_pkg::OP_READ: begin
              q_range_nxt = ({1'b0, in_query_vertex} >= used_n);
              state_nxt   = S_QOUT;
            end
            default: begin
            end
          endcase
        end
      end
      S_INIT: begin
        dist_we    = 1'b1;
        dist_waddr = init_cnt_r[spr_pkg::VADDR_W-1:0];
        if ((init_cnt_r[spr_pkg::VADDR_W-1:0] == source_vertex_r) &&
            ({1'b0, source_vertex_r} < used_n)) begin
          dist_wdata = '0;
        end else begin
          dist_wdata = spr_pkg::INF;
        end
        init_cnt_nxt = init_cnt_r + spr_pkg::VIDX_W'(1);
        if (init_cnt_r == spr_pkg::VIDX_W'(spr_pkg::MAX_VERTICES - 1)) begin
          edge_idx_nxt = '0;
          pass_nxt     = '0;
          changed_nxt  = 1'b0;
          state_nxt    = (used_n > spr_pkg::VCOUNT_W'(1)) ? S_PASS_CHK : S_DONE;
        end
      end
      S_PASS_CHK: begin
        if (edge_idx_r == edges_loaded_r) begin
          if (!changed_r || (pass_next_cnt >= used_n)) begin
            state_nxt = S_DONE;
          end else begin
            pass_nxt     = pass_r + spr_pkg::VADDR_W'(1);
            edge_idx_nxt = '0;
            changed_nxt  = 1'b0;
          end
        end else begin
          state_nxt = S_EDGE_RD;
        end
      end
      S_EDGE_RD: begin
        state_nxt = S_DIST_RD;
      end
      S_DIST_RD: begin
        if (relax_hit) begin
          dist_we     = 1'b1;
          changed_nxt = 1'b1;
        end
        edge_idx_nxt = edge_idx_r + spr_pkg::ECOUNT_W'(1);
        state_nxt    = S_PASS_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_kind_nxt      = spr_pkg::KIND_RUN;
          out_dist_nxt      = '0;
          out_unr_nxt       = 1'b0;
          out_status_nxt    = edges_dropped_r ? spr_pkg::ST_DROPPED : spr_pkg::ST_OK;
          edges_loaded_nxt  = '0;
          edges_dropped_nxt = 1'b0;
          state_nxt         = S_IDLE;
        end
      end
      S_QOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = spr_pkg::KIND_READ;
          if (q_range_r) begin
            out_dist_nxt   = spr_pkg::INF;
            out_unr_nxt    = 1'b1;
            out_status_nxt = spr_pkg::ST_RANGE;
          end else begin
            out_dist_nxt   = dist_a_q;
            out_unr_nxt    = (dist_a_q == spr_pkg::INF);
            out_status_nxt = spr_pkg::ST_OK;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      vertex_count_r  <= spr_pkg::VCOUNT_RESET;
      source_vertex_r <= '0;
      edges_loaded_r  <= '0;
      edges_dropped_r <= 1'b0;
      init_cnt_r      <= '0;
      edge_idx_r      <= '0;
      pass_r          <= '0;
      changed_r       <= 1'b0;
      q_range_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      edges_loaded_r  <= edges_loaded_nxt;
      edges_dropped_r <= edges_dropped_nxt;
      init_cnt_r      <= init_cnt_nxt;
      edge_idx_r      <= edge_idx_nxt;
      pass_r          <= pass_nxt;
      changed_r       <= changed_nxt;
      q_range_r       <= q_range_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          spr_pkg::CFG_VERTEX_COUNT:  vertex_count_r  <= cfg_data;
          spr_pkg::CFG_SOURCE_VERTEX: source_vertex_r <= cfg_data[spr_pkg::VERTEX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_dist_r   <= out_dist_nxt;
    out_unr_r    <= out_unr_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edges_loaded_r[spr_pkg::EADDR_W-1:0]] <= '{weight: in_edge_weight,
                                                         to:     in_edge_to,
                                                         from:   in_edge_from};
    end
    edge_q <= edge_mem[edge_idx_r[spr_pkg::EADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (dist_rd_en) begin
      dist_a_q <= dist_mem[dist_addr_a];
      dist_b_q <= dist_mem[dist_addr_b];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_distance    = out_dist_r;
  assign out_unreachable = out_unr_r;
  assign out_status      = out_status_r;

  a_edges_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    edges_loaded_r <= spr_pkg::ECOUNT_W'(spr_pkg::MAX_EDGES))
    else $error("edge count exceeds the edge memory");

  a_run_clears_edges: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_free |=> (edges_loaded_r == '0) && !edges_dropped_r)
    else $error("edge list not cleared after a run");

  a_unreachable_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_unr_r == (out_dist_r == spr_pkg::INF)))
    else $error("unreachable flag disagrees with the distance");

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS_CHK) |-> ({1'b0, pass_r} + spr_pkg::VCOUNT_W'(1) < used_n))
    else $error("pass count beyond vertex_count-1");

endmodule

`default_nettype wire
